/* hdl/l2g_pkg.sv */
// Shared constants, types and the restoring-division step for linear_to_grid_coordinates.
package l2g_pkg;

  localparam int unsigned MaxDims  = 4;
  localparam int unsigned IdxW     = 31;
  localparam int unsigned CoordW   = 16;
  localparam int unsigned DimCntW  = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned DivSteps = IdxW;
  localparam int unsigned StepCntW = $clog2(DivSteps);
  localparam int unsigned SlotW    = $clog2(MaxDims);
  localparam int unsigned MinDims  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DIM_COUNT   = 3'd0,
    REG_TOTAL_CELLS = 3'd1,
    REG_GRID_D0     = 3'd2,
    REG_GRID_D1     = 3'd3,
    REG_GRID_D2     = 3'd4,
    REG_GRID_D3     = 3'd5
  } reg_idx_e;

  // partial remainder and dividend/quotient shift word
  typedef struct packed {
    logic [IdxW-1:0] rem;
    logic [IdxW-1:0] quo;
  } div_rq_t;

  typedef struct packed {
    logic                           err;
    logic [MaxDims-1:0][CoordW-1:0] coord;
  } side_t;

  typedef struct packed {
    logic                         busy;
    logic [IdxW-1:0]              total;
    logic [MaxDims-1:0][IdxW-1:0] div;
  } cfg_status_t;

  // peel order: dim 3, dim 2, dim 0, dim 1
  function automatic logic [SlotW-1:0] slot_dim(logic [SlotW-1:0] slot);
    logic [SlotW-1:0] dim;
    unique case (slot)
      2'd0:    dim = 2'd3;
      2'd1:    dim = 2'd2;
      2'd2:    dim = 2'd0;
      default: dim = 2'd1;
    endcase
    return dim;
  endfunction

  // one restoring step; a zero divisor gives all-ones quotient, remainder = dividend
  function automatic div_rq_t div_step(div_rq_t rq, logic [IdxW-1:0] dvs);
    logic [IdxW:0] trial;
    logic [IdxW:0] diff;
    logic          ge;
    div_rq_t       res;
    trial    = {rq.rem, rq.quo[IdxW-1]};
    diff     = trial - {1'b0, dvs};
    ge       = (trial >= {1'b0, dvs});
    res.rem  = ge ? diff[IdxW-1:0] : trial[IdxW-1:0];
    res.quo  = {rq.quo[IdxW-2:0], ge};
    return res;
  endfunction

endpackage

/* hdl/l2g_cfg.sv */
// Configuration registers and sequential precompute of the per-slot running divisors.
module l2g_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [l2g_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [l2g_pkg::IdxW-1:0]        cfg_data_i,
  output l2g_pkg::cfg_status_t            status_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_RUN  = 3'b100
  } seq_state_e;

  logic [l2g_pkg::DimCntW-1:0]                      dim_q;
  logic [l2g_pkg::IdxW-1:0]                         total_q;
  logic [l2g_pkg::MaxDims-1:0][l2g_pkg::CoordW-1:0] size_q;

  seq_state_e                                     state_q, state_d;
  logic [l2g_pkg::SlotW-1:0]                      slot_q, slot_d;
  logic [l2g_pkg::StepCntW-1:0]                   step_q, step_d;
  l2g_pkg::div_rq_t                               rq_q, rq_d;
  logic [l2g_pkg::MaxDims-1:0][l2g_pkg::IdxW-1:0] t_q, t_d;

  logic [l2g_pkg::DimCntW-1:0] dims_use;
  logic [l2g_pkg::SlotW-1:0]   cur_dim;
  logic [l2g_pkg::IdxW-1:0]    cur_size;
  logic                        last_step;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q   <= l2g_pkg::DimCntW'(l2g_pkg::MinDims);
      total_q <= l2g_pkg::IdxW'(1);
      size_q  <= {l2g_pkg::MaxDims{l2g_pkg::CoordW'(1)}};
    end else if (cfg_valid_i) begin
      unique case (l2g_pkg::reg_idx_e'(cfg_index_i))
        l2g_pkg::REG_DIM_COUNT:   dim_q     <= cfg_data_i[l2g_pkg::DimCntW-1:0];
        l2g_pkg::REG_TOTAL_CELLS: total_q   <= cfg_data_i;
        l2g_pkg::REG_GRID_D0:     size_q[0] <= cfg_data_i[l2g_pkg::CoordW-1:0];
        l2g_pkg::REG_GRID_D1:     size_q[1] <= cfg_data_i[l2g_pkg::CoordW-1:0];
        l2g_pkg::REG_GRID_D2:     size_q[2] <= cfg_data_i[l2g_pkg::CoordW-1:0];
        l2g_pkg::REG_GRID_D3:     size_q[3] <= cfg_data_i[l2g_pkg::CoordW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (dim_q < l2g_pkg::DimCntW'(l2g_pkg::MinDims)) begin
      dims_use = l2g_pkg::DimCntW'(l2g_pkg::MinDims);
    end else if (dim_q > l2g_pkg::DimCntW'(l2g_pkg::MaxDims)) begin
      dims_use = l2g_pkg::DimCntW'(l2g_pkg::MaxDims);
    end else begin
      dims_use = dim_q;
    end
  end

  // unused dimension divides by one, leaving the running divisor unchanged
  assign cur_dim   = l2g_pkg::slot_dim(slot_q);
  assign cur_size  = ({1'b0, cur_dim} >= dims_use) ? l2g_pkg::IdxW'(1)
                                                    : l2g_pkg::IdxW'(size_q[cur_dim]);
  assign last_step = (step_q == l2g_pkg::StepCntW'(l2g_pkg::DivSteps - 1));

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    step_d  = step_q;
    rq_d    = rq_q;
    t_d     = t_q;
    unique case (state_q)
      ST_IDLE: ;
      ST_LOAD: begin
        rq_d.rem = '0;
        rq_d.quo = (slot_q == '0) ? total_q : rq_q.quo;
        step_d   = '0;
        state_d  = ST_RUN;
      end
      ST_RUN: begin
        rq_d   = l2g_pkg::div_step(rq_q, cur_size);
        step_d = step_q + l2g_pkg::StepCntW'(1);
        if (last_step) begin
          t_d[slot_q] = rq_d.quo;
          slot_d      = slot_q + l2g_pkg::SlotW'(1);
          state_d     = (slot_q == l2g_pkg::SlotW'(l2g_pkg::MaxDims - 1)) ? ST_IDLE : ST_LOAD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_valid_i) begin
      state_d = ST_LOAD;
      slot_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= '0;
      step_q  <= '0;
      t_q     <= {l2g_pkg::MaxDims{l2g_pkg::IdxW'(1)}};
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      step_q  <= step_d;
      t_q     <= t_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rq_q <= rq_d;
  end

  assign status_o.busy  = (state_q != ST_IDLE);
  assign status_o.total = total_q;
  assign status_o.div   = t_q;

  a_write_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> state_q == ST_LOAD)
    else $error("config write did not restart divisor precompute");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> step_q <= l2g_pkg::StepCntW'(l2g_pkg::DivSteps - 1))
    else $error("divide step counter out of range");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN && last_step && slot_q == l2g_pkg::SlotW'(l2g_pkg::MaxDims - 1)
      && !cfg_valid_i |=> state_q == ST_IDLE)
    else $error("precompute did not finish after last slot");

endmodule

/* hdl/l2g_div_pipe.sv */
// Fully pipelined restoring divider, one quotient bit per stage, with side payload.
module l2g_div_pipe (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [l2g_pkg::IdxW-1:0]  dividend_i,
  input  logic [l2g_pkg::IdxW-1:0]  divisor_i,
  input  l2g_pkg::side_t            side_i,
  output logic                      valid_o,
  output logic [l2g_pkg::IdxW-1:0]  quo_o,
  output logic [l2g_pkg::IdxW-1:0]  rem_o,
  output l2g_pkg::side_t            side_o
);

  logic             valid_q [l2g_pkg::DivSteps];
  l2g_pkg::div_rq_t rq_q    [l2g_pkg::DivSteps];
  l2g_pkg::div_rq_t rq_d    [l2g_pkg::DivSteps];
  l2g_pkg::side_t   side_q  [l2g_pkg::DivSteps];
  l2g_pkg::div_rq_t rq_in;

  assign rq_in.rem = '0;
  assign rq_in.quo = dividend_i;

  always_comb begin
    rq_d[0] = l2g_pkg::div_step(rq_in, divisor_i);
    for (int s = 1; s < l2g_pkg::DivSteps; s++) begin
      rq_d[s] = l2g_pkg::div_step(rq_q[s-1], divisor_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < l2g_pkg::DivSteps; s++) begin
        valid_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int s = 1; s < l2g_pkg::DivSteps; s++) begin
        valid_q[s] <= valid_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 0; s < l2g_pkg::DivSteps; s++) begin
        rq_q[s] <= rq_d[s];
      end
      for (int s = 1; s < l2g_pkg::DivSteps; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o = valid_q[l2g_pkg::DivSteps-1];
  assign quo_o   = rq_q[l2g_pkg::DivSteps-1].quo;
  assign rem_o   = rq_q[l2g_pkg::DivSteps-1].rem;
  assign side_o  = side_q[l2g_pkg::DivSteps-1];

endmodule

/* hdl/linear_to_grid_coordinates.sv */
// Top level: splits a linear cell index into grid coordinates through four chained dividers.
//
// Usage:
//   Input channel in_valid_i / in_stall_o carries linear_index_i; a transaction
//   completes on a clock edge with valid high and stall low. Output channel
//   out_valid_o / out_stall_i carries coord_0_o..coord_3_o and index_error_o.
//   Registers are written over cfg_valid_i / cfg_ready_o with cfg_index_i and
//   cfg_data_i; cfg_ready_o is always high.
//   An input transaction passes through four dividers of 31 one-bit stages each.
//   Throughput: one transaction per cycle while in_stall_o is low (no recompute, no output stall).
//   After any register write the running divisors are recomputed on a single
//   iterative divider, during which in_stall_o is high.
//   Reset: registers return to dim_count 2 and all others 1, the pipeline is
//   emptied and no recompute is needed.
//   When out_stall_i holds back a valid result the whole pipeline freezes and
//   in_stall_o is raised; nothing is dropped or repeated.
module linear_to_grid_coordinates (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [l2g_pkg::IdxW-1:0]      linear_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [l2g_pkg::CoordW-1:0]    coord_0_o,
  output logic [l2g_pkg::CoordW-1:0]    coord_1_o,
  output logic [l2g_pkg::CoordW-1:0]    coord_2_o,
  output logic [l2g_pkg::CoordW-1:0]    coord_3_o,
  output logic                          index_error_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [l2g_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [l2g_pkg::IdxW-1:0]      cfg_data_i
);

  l2g_pkg::cfg_status_t     cfg_st;
  logic                     en;
  logic                     stg_valid [l2g_pkg::MaxDims+1];
  logic [l2g_pkg::IdxW-1:0] stg_rem   [l2g_pkg::MaxDims+1];
  l2g_pkg::side_t           stg_side  [l2g_pkg::MaxDims+1];
  logic                     pipe_valid[l2g_pkg::MaxDims];
  logic [l2g_pkg::IdxW-1:0] pipe_quo  [l2g_pkg::MaxDims];
  l2g_pkg::side_t           pipe_side [l2g_pkg::MaxDims];
  l2g_pkg::side_t           fin;

  l2g_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .status_o    (cfg_st)
  );

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = cfg_st.busy || !en;

  assign stg_rem[0] = linear_index_i;

  always_comb begin
    stg_valid[0]      = in_valid_i && !in_stall_o;
    stg_side[0].err   = (linear_index_i >= cfg_st.total);
    stg_side[0].coord = '0;
    for (int s = 0; s < l2g_pkg::MaxDims; s++) begin
      stg_valid[s+1] = pipe_valid[s];
      stg_side[s+1]  = pipe_side[s];
      stg_side[s+1].coord[l2g_pkg::slot_dim(l2g_pkg::SlotW'(s))] =
        pipe_quo[s][l2g_pkg::CoordW-1:0];
    end
  end

  for (genvar s = 0; s < l2g_pkg::MaxDims; s++) begin : g_slot
    l2g_div_pipe u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .valid_i    (stg_valid[s]),
      .dividend_i (stg_rem[s]),
      .divisor_i  (cfg_st.div[s]),
      .side_i     (stg_side[s]),
      .valid_o    (pipe_valid[s]),
      .quo_o      (pipe_quo[s]),
      .rem_o      (stg_rem[s+1]),
      .side_o     (pipe_side[s])
    );
  end

  assign fin           = stg_side[l2g_pkg::MaxDims];
  assign out_valid_o   = stg_valid[l2g_pkg::MaxDims];
  assign index_error_o = fin.err;
  assign coord_0_o     = fin.err ? '0 : fin.coord[0];
  assign coord_1_o     = fin.err ? '0 : fin.coord[1];
  assign coord_2_o     = fin.err ? '0 : fin.coord[2];
  assign coord_3_o     = fin.err ? '0 : fin.coord[3];

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && index_error_o |-> coord_0_o == '0 && coord_1_o == '0
      && coord_2_o == '0 && coord_3_o == '0)
    else $error("coordinates not cleared on index error");

  a_busy_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cfg_st.busy) |-> $past(cfg_valid_i))
    else $error("divisor recompute started without a register write");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(stg_valid[1]) && $stable(stg_rem[1]))
    else $error("pipeline advanced while output stalled");

endmodule
